FILE: design/lmtf_pkg.sv
`timescale 1ns / 1ps
package lmtf_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam int KEY_BITS_DEF    = 32;
  localparam int IN_KEY_W        = 32;
  localparam int CFG_W           = 4;
  localparam int OCC_W           = 4;
  localparam int MISS_W          = 32;
  localparam int CAP_RESET       = 4;

  typedef struct packed {
    logic upd;
    logic miss;
  } lmtf_ctl_t;

endpackage

FILE: design/lmtf_cell.sv
`timescale 1ns / 1ps
module lmtf_cell
  import lmtf_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  lmtf_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] access_key,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic                held,
  input  logic                found_in,
  output logic                found_out,
  output logic [KEY_BITS-1:0] key_q
);

  logic [KEY_BITS-1:0] key_r;
  logic                match;

  assign match     = held && (key_r == access_key);
  assign found_out = found_in || match;
  assign key_q     = key_r;

  // advance the entry ahead unless the hit lies in front of this place
  always_ff @(posedge clk) begin
    if (ctl.upd && (ctl.miss || !found_in)) begin
      key_r <= prev_key;
    end
  end

endmodule

FILE: design/lru_move_to_front_buffer.sv
`timescale 1ns / 1ps
// Move-to-front LRU buffer of up to MAX_ENTRIES keys.
// Input: a word is taken at a rising edge with start high and busy low.
// busy is high only while a capacity write is presented on cfg_valid.
// Each accepted word yields one result word on the out_ ports, marked by
// out_valid for exactly one cycle, on the cycle after acceptance.
// Throughput is one word per cycle while busy is low: every cell compares its
// key against the incoming key and shifts from its neighbour in the same cycle;
// the found signal ripples along the row of cells, which sets the cycle time.
// The receiver cannot stall; out_valid is a strobe with no back-pressure.
// Capacity port: cfg_capacity is taken when cfg_valid is high (cfg_ready is
// always high); zero reads as one, values above MAX_ENTRIES as MAX_ENTRIES.
// Lowering capacity drops the least recent entries without a result.
// Reset (rst_n low, synchronous) empties the buffer, clears the miss count
// and sets capacity to 4. Keys stored in the cells are not cleared.
module lru_move_to_front_buffer
  import lmtf_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [IN_KEY_W-1:0] in_access_key,
  output logic                out_valid,
  output logic                out_hit,
  output logic                out_evicted,
  output logic [IN_KEY_W-1:0] out_evicted_key,
  output logic [MISS_W-1:0]   out_miss_total,
  output logic [OCC_W-1:0]    out_occupancy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_capacity
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          cap_r, cap_nxt;
  logic [MISS_W-1:0]         miss_r, miss_nxt;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic                      out_evicted_r;
  logic [IN_KEY_W-1:0]       out_evk_r;

  logic                      accept;
  logic                      cfg_wr;
  logic                      hit;
  logic                      evict;
  logic [KEY_BITS-1:0]       key;
  logic [KEY_BITS+IN_KEY_W-1:0] key_ext;
  logic [KEY_BITS+IN_KEY_W-1:0] evk_ext;
  logic [KEY_BITS-1:0]       evk;
  lmtf_ctl_t                 ctl;

  logic [KEY_BITS-1:0]       cell_key [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]      found;
  logic [MAX_ENTRIES-1:0]    held;
  logic [MAX_ENTRIES-1:0]    last_sel;

  assign busy      = cfg_valid;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  assign key_ext = {{KEY_BITS{1'b0}}, in_access_key};
  assign key     = key_ext[KEY_BITS-1:0];

  assign found[0] = 1'b0;
  assign hit      = found[MAX_ENTRIES];
  assign evict    = !hit && (count_r >= cap_r);
  assign ctl.upd  = accept;
  assign ctl.miss = !hit;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [KEY_BITS-1:0] prev;
      if (gi == 0) begin : g_head
        assign prev = key;
      end else begin : g_body
        assign prev = cell_key[gi-1];
      end
      assign held[gi]     = CNT_W'(gi) < count_r;
      assign last_sel[gi] = cap_r == CNT_W'(gi + 1);
      lmtf_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .access_key(key),
        .prev_key  (prev),
        .held      (held[gi]),
        .found_in  (found[gi]),
        .found_out (found[gi+1]),
        .key_q     (cell_key[gi])
      );
    end
  endgenerate

  always_comb begin
    evk = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      evk = evk | (cell_key[i] & {KEY_BITS{last_sel[i]}});
    end
  end

  assign evk_ext = {{IN_KEY_W{1'b0}}, evk};

  always_comb begin
    cap_nxt   = cap_r;
    count_nxt = count_r;
    miss_nxt  = miss_r;
    if (cfg_wr) begin
      if (cfg_capacity == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (int'(cfg_capacity) > MAX_ENTRIES) begin
        cap_nxt = CNT_W'(MAX_ENTRIES);
      end else begin
        cap_nxt = CNT_W'(cfg_capacity);
      end
      if (count_r > cap_nxt) begin
        count_nxt = cap_nxt;
      end
    end else if (accept && !hit) begin
      if (miss_r != '1) begin
        miss_nxt = miss_r + MISS_W'(1);
      end
      if (evict) begin
        count_nxt = cap_r;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CNT_W'(CAP_RESET > MAX_ENTRIES ? MAX_ENTRIES : CAP_RESET);
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r     <= hit;
      out_evicted_r <= evict;
      out_evk_r     <= evict ? evk_ext[IN_KEY_W-1:0] : '0;
    end
  end

  logic [CNT_W+OCC_W-1:0] occ_ext;
  assign occ_ext = {{OCC_W{1'b0}}, count_r};

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evk_r;
  assign out_miss_total  = miss_r;
  assign out_occupancy   = occ_ext[OCC_W-1:0];

endmodule

FILE: design/lmtf_checker.sv
`timescale 1ns / 1ps
module lmtf_checker
  import lmtf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [IN_KEY_W-1:0] in_access_key,
  input logic                out_valid,
  input logic                out_hit,
  input logic                out_evicted,
  input logic [IN_KEY_W-1:0] out_evicted_key,
  input logic [MISS_W-1:0]   out_miss_total,
  input logic [OCC_W-1:0]    out_occupancy,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CFG_W-1:0]    cfg_capacity
);

  a_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("accepted word gave no result");

  a_result_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without an accepted word");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && out_occupancy != '0)
    else $error("eviction on a hit or with empty buffer");

  a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key not zero without eviction");

  a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> $stable(out_miss_total))
    else $error("miss count moved on a hit");

endmodule

bind lru_move_to_front_buffer lmtf_checker u_lmtf_checker (.*);

FILE: bench/lru_move_to_front_buffer_tb.sv
`timescale 1ns / 1ps
module lru_move_to_front_buffer_tb;
  import lmtf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [IN_KEY_W-1:0] evicted_key;
    logic [MISS_W-1:0] miss_total;
    logic [OCC_W-1:0]  occupancy;
  } lookup_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [IN_KEY_W-1:0] in_access_key = '0;
  logic                out_valid;
  logic                out_hit;
  logic                out_evicted;
  logic [IN_KEY_W-1:0] out_evicted_key;
  logic [MISS_W-1:0]   out_miss_total;
  logic [OCC_W-1:0]    out_occupancy;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_capacity = '0;

  logic [IN_KEY_W-1:0] pending_keys[$];
  lookup_t             expected_lookups[$];
  int                  idle_pct = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  logic [IN_KEY_W-1:0] mru_keys[MAX_ENTRIES_DEF];
  int unsigned         held_count = 0;
  logic [MISS_W-1:0]   miss_count = '0;
  int unsigned         eff_capacity = CAP_RESET;

  lru_move_to_front_buffer #(
    .MAX_ENTRIES(MAX_ENTRIES_DEF),
    .KEY_BITS   (KEY_BITS_DEF)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_access_key  (in_access_key),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .out_miss_total (out_miss_total),
    .out_occupancy  (out_occupancy),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  always #4 clk = ~clk;

  function automatic int unsigned clamp_capacity(logic [CFG_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
    return value;
  endfunction

  function automatic void apply_capacity(logic [CFG_W-1:0] value);
    eff_capacity = clamp_capacity(value);
    if (held_count > eff_capacity) held_count = eff_capacity;
  endfunction

  function automatic lookup_t lookup_and_promote(logic [IN_KEY_W-1:0] key);
    lookup_t     r;
    int unsigned slot;
    int unsigned i;
    r = '0;
    slot = held_count;
    for (i = 0; i < held_count; i++)
      if (slot == held_count && mru_keys[i] == key) slot = i;
    if (slot < held_count) begin
      r.hit = 1'b1;
    end else begin
      if (miss_count != '1) miss_count++;
      if (held_count >= eff_capacity) begin
        r.evicted     = 1'b1;
        r.evicted_key = mru_keys[eff_capacity-1];
        held_count    = eff_capacity - 1;
      end
      slot = held_count;
      held_count++;
    end
    for (i = slot; i > 0; i--) mru_keys[i] = mru_keys[i-1];
    mru_keys[0] = key;
    r.miss_total = miss_count;
    r.occupancy  = held_count[OCC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_move_to_front_buffer: mismatch");
      $finish;
    end
  end

  // driver: present pending keys, hold while busy
  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_lookups.push_back(lookup_and_promote(in_access_key));
        void'(pending_keys.pop_front());
      end
      if (!(start && busy)) begin
        go = pending_keys.size() != 0 && $urandom_range(99) >= idle_pct;
        start <= go;
        if (go) in_access_key <= pending_keys[0];
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n && out_valid) begin
      got = {out_hit, out_evicted, out_evicted_key, out_miss_total, out_occupancy};
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: hit=%0b evicted=%0b key=%h misses=%0d occ=%0d",
                   got.hit, got.evicted, got.evicted_key, got.miss_total, got.occupancy);
      end else begin
        want = expected_lookups.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("exp hit=%0b evicted=%0b key=%h misses=%0d occ=%0d | got hit=%0b evicted=%0b key=%h misses=%0d occ=%0d",
                     want.hit, want.evicted, want.evicted_key, want.miss_total,
                     want.occupancy, got.hit, got.evicted, got.evicted_key,
                     got.miss_total, got.occupancy);
        end
      end
    end
  end

  task automatic drain();
    while (pending_keys.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_capacity(value);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0]    phase_caps[10];
    int                  phase_idle[3];
    logic [IN_KEY_W-1:0] pool[$];
    int unsigned         pool_n;
    int                  p;
    int                  k;

    phase_caps = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};
    phase_idle = '{0, 87, 37};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: fill, evict, hits at the back and in second place
    pending_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001};
    drain();

    write_capacity(4'd1);
    pending_keys = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    drain();

    write_capacity(4'd0);
    pending_keys = '{32'h1234_5678, 32'h1234_5678};
    drain();

    write_capacity(4'd15);
    for (k = 1; k <= 9; k++) pending_keys.push_back(32'h0101_0101 * k);
    pending_keys.push_back(32'h0202_0202);
    drain();

    write_capacity(4'd9);
    write_capacity(4'd2);
    pending_keys.push_back(32'h0303_0303);
    drain();

    for (p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      idle_pct = phase_idle[p % 3];
      pool_n = clamp_capacity(phase_caps[p]) + 2;
      pool.delete();
      for (k = 0; k < pool_n; k++) pool.push_back($urandom);
      for (k = 0; k < 100; k++) begin
        if ($urandom_range(99) < 75)
          pending_keys.push_back(pool[$urandom_range(pool_n - 1)]);
        else
          pending_keys.push_back($urandom);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0)
      $display("lru_move_to_front_buffer: match");
    else
      $display("lru_move_to_front_buffer: mismatch");
    $finish;
  end

endmodule
